FILE: src/rdc_pkg.sv
// Shared constants, types and command codes of the range distinct count unit.
package rdc_pkg;

	// sizes of the element store and the value frequency table
	localparam int ARRAY_DEPTH = 1024;
	localparam int VALUE_COUNT = 1024;

	// field widths
	localparam int IDX_W  = 11;
	localparam int VAL_W  = 10;
	localparam int CNT_W  = 11;
	localparam int FREQ_W = 11;

	// memory address widths
	localparam int EA_W = $clog2(ARRAY_DEPTH);
	localparam int FA_W = $clog2(VALUE_COUNT);

	// command codes of an input item
	localparam logic CMD_LOAD  = 1'b0;
	localparam logic CMD_QUERY = 1'b1;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_STEP,
		ST_FREQ,
		ST_UPD
	} rdc_state_t;

	// controller to datapath
	typedef struct packed {
		logic clear_wr;
		logic load_wr;
		logic query_cap;
		logic err_out;
		logic step;
		logic freq_rd;
		logic upd;
		logic result_out;
	} rdc_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic clear_last;
		logic load_ok;
		logic query_ok;
		logic move_pending;
	} rdc_stat_t;

endpackage

FILE: src/rdc_ram.sv
// Generic single-write, single-read RAM with registered read data.
module rdc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read, hold data between reads
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

FILE: src/rdc_ctrl.sv
// Controller state machine: clearing pass, item decode and window stepping.
module rdc_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic              command,
	input  rdc_pkg::rdc_stat_t stat,
	output rdc_pkg::rdc_cmd_t  cmd,
	output logic              busy
);

	rdc_pkg::rdc_state_t state_q;
	rdc_pkg::rdc_state_t state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rdc_pkg::ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			rdc_pkg::ST_CLEAR: begin
				cmd.clear_wr = 1'b1;
				if (stat.clear_last) begin
					state_d = rdc_pkg::ST_IDLE;
				end
			end
			rdc_pkg::ST_IDLE: begin
				if (start) begin
					if (command == rdc_pkg::CMD_LOAD) begin
						if (stat.load_ok) begin
							cmd.load_wr = 1'b1;
						end else begin
							cmd.err_out = 1'b1;
						end
					end else if (stat.query_ok) begin
						cmd.query_cap = 1'b1;
						state_d       = rdc_pkg::ST_STEP;
					end else begin
						cmd.err_out = 1'b1;
					end
				end
			end
			rdc_pkg::ST_STEP: begin
				if (stat.move_pending) begin
					cmd.step = 1'b1;
					state_d  = rdc_pkg::ST_FREQ;
				end else begin
					cmd.result_out = 1'b1;
					state_d        = rdc_pkg::ST_IDLE;
				end
			end
			rdc_pkg::ST_FREQ: begin
				cmd.freq_rd = 1'b1;
				state_d     = rdc_pkg::ST_UPD;
			end
			rdc_pkg::ST_UPD: begin
				cmd.upd = 1'b1;
				state_d = rdc_pkg::ST_STEP;
			end
			default: begin
				state_d = rdc_pkg::ST_CLEAR;
			end
		endcase
	end

	assign busy = (state_q != rdc_pkg::ST_IDLE);

endmodule

FILE: src/rdc_dpath.sv
// Datapath: element store, frequency table, window pointers and result registers.
module rdc_dpath (
	input  logic                        clk,
	input  logic                        arst_n,
	input  rdc_pkg::rdc_cmd_t           cmd,
	output rdc_pkg::rdc_stat_t          stat,
	input  logic [rdc_pkg::IDX_W-1:0]   load_index,
	input  logic [rdc_pkg::VAL_W-1:0]   load_value,
	input  logic [rdc_pkg::IDX_W-1:0]   query_left,
	input  logic [rdc_pkg::IDX_W-1:0]   query_right,
	output logic                        done,
	output logic [rdc_pkg::CNT_W-1:0]   distinct_count,
	output logic                        request_error
);

	logic [rdc_pkg::FA_W-1:0]   clr_q;
	logic [rdc_pkg::IDX_W-1:0]  wl_q;
	logic [rdc_pkg::IDX_W-1:0]  wr_q;
	logic [rdc_pkg::IDX_W-1:0]  ql_q;
	logic [rdc_pkg::IDX_W-1:0]  qr_q;
	logic [rdc_pkg::IDX_W-1:0]  highest_q;
	logic                       started_q;
	logic [rdc_pkg::CNT_W-1:0]  total_q;
	logic                       enter_q;
	logic                       done_q;
	logic [rdc_pkg::CNT_W-1:0]  count_q;
	logic                       err_q;

	logic                       grow_l;
	logic                       grow_r;
	logic                       shr_l;
	logic                       shr_r;
	logic [rdc_pkg::IDX_W-1:0]  pos;
	logic [rdc_pkg::VAL_W-1:0]  elem_rdata;
	logic [rdc_pkg::FREQ_W-1:0] freq_rdata;
	logic [rdc_pkg::FREQ_W-1:0] freq_new;
	logic                       freq_wr;
	logic                       freq_we;
	logic [rdc_pkg::FA_W-1:0]   freq_waddr;
	logic [rdc_pkg::FREQ_W-1:0] freq_wdata;

	// check incoming items
	assign stat.load_ok = !started_q && (load_index != '0) &&
		(32'(load_index) <= rdc_pkg::ARRAY_DEPTH) &&
		(32'(load_value) < rdc_pkg::VALUE_COUNT);
	assign stat.query_ok = (query_left != '0) && (query_left <= query_right) &&
		(query_right <= highest_q);
	assign stat.clear_last = (clr_q == rdc_pkg::FA_W'(rdc_pkg::VALUE_COUNT - 1));

	// pick next window move: grow first, then shrink
	assign grow_l = (wl_q > ql_q);
	assign grow_r = (wr_q < qr_q);
	assign shr_l  = (wl_q < ql_q);
	assign shr_r  = (wr_q > qr_q);
	assign stat.move_pending = grow_l || grow_r || shr_l || shr_r;

	always_comb begin
		if (grow_l) begin
			pos = wl_q - 1'b1;
		end else if (grow_r) begin
			pos = wr_q + 1'b1;
		end else if (shr_l) begin
			pos = wl_q;
		end else begin
			pos = wr_q;
		end
	end

	// element store
	rdc_ram #(
		.WIDTH(rdc_pkg::VAL_W),
		.DEPTH(rdc_pkg::ARRAY_DEPTH)
	) u_elem_ram (
		.clk  (clk),
		.we   (cmd.load_wr),
		.waddr(rdc_pkg::EA_W'(load_index - 1'b1)),
		.wdata(load_value),
		.re   (cmd.step),
		.raddr(rdc_pkg::EA_W'(pos - 1'b1)),
		.rdata(elem_rdata)
	);

	// frequency update: raise on enter, lower on leave unless already zero
	always_comb begin
		if (enter_q) begin
			freq_new = freq_rdata + 1'b1;
			freq_wr  = 1'b1;
		end else begin
			freq_new = freq_rdata - 1'b1;
			freq_wr  = (freq_rdata != '0);
		end
	end

	assign freq_we    = cmd.clear_wr || (cmd.upd && freq_wr);
	assign freq_waddr = cmd.clear_wr ? clr_q : rdc_pkg::FA_W'(elem_rdata);
	assign freq_wdata = cmd.clear_wr ? '0 : freq_new;

	// value frequency table
	rdc_ram #(
		.WIDTH(rdc_pkg::FREQ_W),
		.DEPTH(rdc_pkg::VALUE_COUNT)
	) u_freq_ram (
		.clk  (clk),
		.we   (freq_we),
		.waddr(freq_waddr),
		.wdata(freq_wdata),
		.re   (cmd.freq_rd),
		.raddr(rdc_pkg::FA_W'(elem_rdata)),
		.rdata(freq_rdata)
	);

	// clear sweep counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (cmd.clear_wr) begin
			clr_q <= clr_q + 1'b1;
		end
	end

	// window pointers, query bounds, load high mark
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wl_q      <= rdc_pkg::IDX_W'(1);
			wr_q      <= '0;
			ql_q      <= '0;
			qr_q      <= '0;
			highest_q <= '0;
			started_q <= 1'b0;
			enter_q   <= 1'b0;
		end else begin
			if (cmd.load_wr && (load_index > highest_q)) begin
				highest_q <= load_index;
			end
			if (cmd.query_cap) begin
				ql_q      <= query_left;
				qr_q      <= query_right;
				started_q <= 1'b1;
			end
			if (cmd.step) begin
				enter_q <= grow_l || grow_r;
				if (grow_l) begin
					wl_q <= wl_q - 1'b1;
				end else if (grow_r) begin
					wr_q <= wr_q + 1'b1;
				end else if (shr_l) begin
					wl_q <= wl_q + 1'b1;
				end else begin
					wr_q <= wr_q - 1'b1;
				end
			end
		end
	end

	// distinct total: bump on zero to one, drop on one to zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= '0;
		end else if (cmd.upd) begin
			if (enter_q && (freq_rdata == '0)) begin
				total_q <= total_q + 1'b1;
			end else if (!enter_q && (freq_rdata == rdc_pkg::FREQ_W'(1))) begin
				total_q <= total_q - 1'b1;
			end
		end
	end

	// result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= cmd.err_out || cmd.result_out;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (cmd.err_out) begin
			count_q <= '0;
			err_q   <= 1'b1;
		end else if (cmd.result_out) begin
			count_q <= total_q;
			err_q   <= 1'b0;
		end
	end

	assign done           = done_q;
	assign distinct_count = count_q;
	assign request_error  = err_q;

endmodule

FILE: src/range_distinct_count_unit.sv
// Range distinct count unit: top level joining controller and datapath.
// After reset the frequency table is cleared, all VALUE_COUNT (1024) entries, with busy high.
// A good load is written as it is accepted and gives no result; a rejected item gives its result
// in the cycle after acceptance. A query steps the window pointers after acceptance, each
// step being one element read, one frequency read and one frequency write-back, and then
// registers its result. Results are a one-cycle strobe on done; the receiver cannot stall.
module range_distinct_count_unit (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	output logic                      busy,
	input  logic                      command,
	input  logic [rdc_pkg::IDX_W-1:0] load_index,
	input  logic [rdc_pkg::VAL_W-1:0] load_value,
	input  logic [rdc_pkg::IDX_W-1:0] query_left,
	input  logic [rdc_pkg::IDX_W-1:0] query_right,
	output logic                      done,
	output logic [rdc_pkg::CNT_W-1:0] distinct_count,
	output logic                      request_error
);

	rdc_pkg::rdc_cmd_t  cmd;
	rdc_pkg::rdc_stat_t stat;

	// sequence control
	rdc_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.command(command),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy)
	);

	// storage and arithmetic
	rdc_dpath u_dpath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.stat          (stat),
		.load_index    (load_index),
		.load_value    (load_value),
		.query_left    (query_left),
		.query_right   (query_right),
		.done          (done),
		.distinct_count(distinct_count),
		.request_error (request_error)
	);

`ifndef ASSERT_OFF
	// an error result carries a zero count
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && request_error |-> distinct_count == '0)
		else $error("error result with nonzero count");

	// a finished query shows up as a good result in the next cycle
	a_result_next: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.result_out |=> done && !request_error)
		else $error("query result not delivered");

	// the clearing pass never overlaps accepted items
	a_clear_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.clear_wr |-> busy && !cmd.load_wr && !cmd.query_cap)
		else $error("item taken during clearing pass");

	// a count never exceeds the array depth
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		done && !request_error |-> 32'(distinct_count) <= rdc_pkg::ARRAY_DEPTH)
		else $error("distinct count out of range");
`endif

endmodule

FILE: tb/sv/range_distinct_count_unit_tb.sv
// Self-checking testbench for the range distinct count unit: loads, window queries, rejects.
module range_distinct_count_unit_tb;
	import rdc_pkg::*;

	localparam int HALF_PERIOD    = 5;
	localparam int RESET_CYCLES   = 7;
	localparam int WATCHDOG_LIMIT = 20000;
	localparam int QUERY_ITEMS    = 350;
	localparam int CALM_ITEMS     = 60;
	localparam int SETTLE_CYCLES  = 16;
	localparam int REPORT_CAP     = 50;
	localparam int LOAD_TOP       = 400;
	localparam int RING_DEPTH     = 64;

	// Track the loaded array and predict the count of each query in arrival order.
	class distinct_scoreboard;
		logic [VAL_W-1:0] element_copy [ARRAY_DEPTH];
		int unsigned      top_index;
		bit               querying;
		logic [CNT_W-1:0] want_count [RING_DEPTH];
		logic             want_error [RING_DEPTH];
		int unsigned      rd_ptr;
		int unsigned      wr_ptr;
		int unsigned      mismatches;
		int unsigned      answered;
		int unsigned      rejected;
		int unsigned      stored;

		function new();
			top_index  = 0;
			querying   = 0;
			rd_ptr     = 0;
			wr_ptr     = 0;
			mismatches = 0;
			answered   = 0;
			rejected   = 0;
			stored     = 0;
		endfunction

		// Queue one expected result behind the ones already waiting.
		function void queue_result(logic [CNT_W-1:0] cnt, logic err);
			want_count[wr_ptr % RING_DEPTH] = cnt;
			want_error[wr_ptr % RING_DEPTH] = err;
			wr_ptr++;
		endfunction

		function void push_reject();
			queue_result('0, 1'b1);
			rejected++;
		endfunction

		// Note one accepted item and queue the result it causes, if any.
		function void note_item(logic cmd, logic [IDX_W-1:0] li, logic [VAL_W-1:0] lv,
				logic [IDX_W-1:0] ql, logic [IDX_W-1:0] qr);
			bit          seen [VALUE_COUNT];
			int unsigned k;
			int unsigned tally;
			if (cmd == CMD_LOAD) begin
				if (querying || li == 0 || li > ARRAY_DEPTH || lv >= VALUE_COUNT) begin
					push_reject();
				end else begin
					element_copy[li - 1] = lv;
					if (li > top_index)
						top_index = li;
					stored++;
				end
			end else if (ql == 0 || ql > qr || qr > top_index) begin
				push_reject();
			end else begin
				querying = 1;
				foreach (seen[i])
					seen[i] = 0;
				tally = 0;
				// count each value once over the inclusive range
				for (k = ql; k <= qr; k++) begin
					if (!seen[element_copy[k - 1]]) begin
						seen[element_copy[k - 1]] = 1;
						tally++;
					end
				end
				queue_result(tally[CNT_W-1:0], 1'b0);
				answered++;
			end
		endfunction

		// Compare one result with the oldest queued expectation.
		function void check_result(logic [CNT_W-1:0] cnt, logic err);
			logic [CNT_W-1:0] exp_cnt;
			logic             exp_err;
			if (rd_ptr == wr_ptr) begin
				if (mismatches < REPORT_CAP)
					$display("%0t: result with nothing pending: count=%0d error=%b",
						$time, cnt, err);
				mismatches++;
				return;
			end
			exp_cnt = want_count[rd_ptr % RING_DEPTH];
			exp_err = want_error[rd_ptr % RING_DEPTH];
			rd_ptr++;
			if (err !== exp_err) begin
				if (mismatches < REPORT_CAP)
					$display("%0t: request_error expected %b actual %b", $time, exp_err, err);
				mismatches++;
			end
			if (cnt !== exp_cnt) begin
				if (mismatches < REPORT_CAP)
					$display("%0t: distinct_count expected %0d actual %0d",
						$time, exp_cnt, cnt);
				mismatches++;
			end
		endfunction

		function int unsigned outstanding();
			return wr_ptr - rd_ptr;
		endfunction
	endclass

	logic             clk;
	logic             arst_n;
	logic             start;
	logic             busy;
	logic             command;
	logic [IDX_W-1:0] load_index;
	logic [VAL_W-1:0] load_value;
	logic [IDX_W-1:0] query_left;
	logic [IDX_W-1:0] query_right;
	logic             done;
	logic [CNT_W-1:0] distinct_count;
	logic             request_error;

	distinct_scoreboard sb;
	bit                 gaps_on;
	int unsigned        quiet_cycles;
	int unsigned        items_sent;
	int                 walk_pos;
	int unsigned        load_order [LOAD_TOP - 1];

	range_distinct_count_unit dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.command        (command),
		.load_index     (load_index),
		.load_value     (load_value),
		.query_left     (query_left),
		.query_right    (query_right),
		.done           (done),
		.distinct_count (distinct_count),
		.request_error  (request_error)
	);

	// Toggle the clock.
	initial clk = 1'b0;
	always #(HALF_PERIOD) clk = ~clk;

	// Sample accepted items and results at the rising edge.
	always @(posedge clk) begin
		if (arst_n) begin
			if (done)
				sb.check_result(distinct_count, request_error);
			if (start && !busy)
				sb.note_item(command, load_index, load_value, query_left, query_right);
			if (done || (start && !busy))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
		end
	end

	// End the run when nothing moves for too long.
	initial begin
		wait (quiet_cycles >= WATCHDOG_LIMIT);
		$display("%0t: no item or result for %0d cycles", $time, WATCHDOG_LIMIT);
		$display("Simulation FAILED");
		$finish;
	end

	// Drive one item from a falling edge and hold it until accepted.
	task automatic send_item(input logic cmd, input logic [IDX_W-1:0] li,
			input logic [VAL_W-1:0] lv, input logic [IDX_W-1:0] ql,
			input logic [IDX_W-1:0] qr);
		int unsigned gap;
		if (gaps_on && $urandom_range(0, 99) < 30) begin
			gap = $urandom_range(1, 9);
			start <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		start       <= 1'b1;
		command     <= cmd;
		load_index  <= li;
		load_value  <= lv;
		query_left  <= ql;
		query_right <= qr;
		do
			@(posedge clk);
		while (busy);
		items_sent++;
		@(negedge clk);
	endtask

	task automatic send_load(input int unsigned li, input int unsigned lv);
		send_item(CMD_LOAD, IDX_W'(li), VAL_W'(lv), IDX_W'($urandom), IDX_W'($urandom));
	endtask

	task automatic send_query(input int unsigned ql, input int unsigned qr);
		send_item(CMD_QUERY, IDX_W'($urandom), VAL_W'($urandom), IDX_W'(ql), IDX_W'(qr));
	endtask

	function automatic logic [VAL_W-1:0] pick_value();
		if ($urandom_range(0, 9) < 7)
			return VAL_W'($urandom_range(0, 15));
		return VAL_W'($urandom);
	endfunction

	// Send one item that must be rejected: bad load or bad range.
	task automatic send_noise(input bit queries_begun);
		int unsigned ql;
		int unsigned qr;
		case ($urandom_range(0, 3))
			0: begin
				if (queries_begun)
					send_load($urandom_range(0, 2047), $urandom);
				else if ($urandom_range(0, 1) == 0)
					send_load(0, $urandom);
				else
					send_load($urandom_range(ARRAY_DEPTH + 1, 2047), $urandom);
			end
			1: send_query(0, $urandom_range(0, 2047));
			2: begin
				ql = $urandom_range(2, 2047);
				qr = $urandom_range(0, ql - 1);
				send_query(ql, qr);
			end
			default: begin
				qr = $urandom_range(ARRAY_DEPTH + 1, 2047);
				ql = $urandom_range(1, qr);
				send_query(ql, qr);
			end
		endcase
	endtask

	// Send a valid query inside the loaded span, mostly a short window near the last one.
	task automatic send_window_query();
		int ql;
		int qr;
		if ($urandom_range(0, 19) == 0) begin
			ql = $urandom_range(1, LOAD_TOP);
			qr = $urandom_range(ql, LOAD_TOP);
		end else begin
			walk_pos = walk_pos + int'($urandom_range(0, 80)) - 40;
			if (walk_pos < 1)
				walk_pos = 1;
			if (walk_pos > LOAD_TOP)
				walk_pos = LOAD_TOP;
			ql = walk_pos;
			qr = ql + int'($urandom_range(0, 40));
			if (qr > LOAD_TOP)
				qr = LOAD_TOP;
		end
		send_query(ql, qr);
	endtask

	initial begin
		int unsigned k;
		int unsigned j;
		int unsigned swap;
		sb           = new();
		gaps_on      = 1;
		quiet_cycles = 0;
		items_sent   = 0;
		walk_pos     = LOAD_TOP / 2;
		arst_n       = 1'b0;
		start        = 1'b0;
		command      = CMD_LOAD;
		load_index   = '0;
		load_value   = '0;
		query_left   = '0;
		query_right  = '0;

		// Hold reset, then release at a falling edge.
		repeat (RESET_CYCLES) @(negedge clk);
		arst_n <= 1'b1;

		// Reject queries on an empty array and loads outside the array.
		send_query(1, 1);
		send_query(0, 0);
		send_query(2047, 2047);
		send_load(0, 5);
		send_load(ARRAY_DEPTH + 1, 7);
		send_load(2047, 1023);
		// Store the extremes of index and value.
		send_load(1, 0);
		send_load(ARRAY_DEPTH, 1023);

		// Load the rest of the low span in shuffled order, with overwrites and rejects.
		for (k = 0; k < LOAD_TOP - 1; k++)
			load_order[k] = k + 2;
		for (k = LOAD_TOP - 2; k > 0; k--) begin
			j             = $urandom_range(0, k);
			swap          = load_order[k];
			load_order[k] = load_order[j];
			load_order[j] = swap;
		end
		for (k = 0; k < LOAD_TOP - 1; k++) begin
			if ($urandom_range(0, 99) < 5)
				send_noise(0);
			if ($urandom_range(0, 99) < 3)
				send_load(load_order[$urandom_range(0, k)], pick_value());
			send_load(load_order[k], pick_value());
		end

		// Query the ends, the whole low span twice, and every rejected form.
		send_query(1, 1);
		send_query(LOAD_TOP, LOAD_TOP);
		send_query(1, LOAD_TOP);
		send_query(1, LOAD_TOP);
		send_query(LOAD_TOP / 2, LOAD_TOP / 2 + 1);
		send_query(5, 3);
		send_query(0, 5);
		send_query(1, ARRAY_DEPTH + 1);
		send_query(2047, 2047);
		send_query(ARRAY_DEPTH, 1);
		// Reject loads once queries have begun.
		send_load(1, 1023);
		send_load(ARRAY_DEPTH, 0);
		send_query(1, 1);

		// Slide the window at random, with some rejected items mixed in.
		for (k = 0; k < QUERY_ITEMS; k++) begin
			if (k == QUERY_ITEMS - CALM_ITEMS)
				gaps_on = 0;
			if ($urandom_range(0, 99) < 20)
				send_noise(1);
			else
				send_window_query();
		end
		start <= 1'b0;

		// Drain pending results, then watch for stray ones.
		while (sb.outstanding() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("Covered %0d items: %0d elements stored, %0d queries answered, %0d rejected.",
			items_sent, sb.stored, sb.answered, sb.rejected);
		$display("Windows slid both ways over the loaded span, with bad ranges and late loads.");
		if (sb.mismatches == 0 && sb.outstanding() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

FILE: range_distinct_count_unit.f
src/rdc_pkg.sv
src/rdc_ram.sv
src/rdc_ctrl.sv
src/rdc_dpath.sv
src/range_distinct_count_unit.sv
tb/sv/range_distinct_count_unit_tb.sv
